/* rtl/mfs_pkg.sv */
package mfs_pkg;

	// Default ring depth, handed to the top level parameter.
	localparam int DEPTH_DEF = 16;

	// Operation codes carried on the input kind field.
	localparam logic [1:0] OP_ENQ   = 2'd0;
	localparam logic [1:0] OP_DEQ   = 2'd1;
	localparam logic [1:0] OP_SRCH  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [15:0]        source;
		logic signed [31:0] message;
	} entry_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        source_id;
		logic signed [31:0] message;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        out_source;
		logic signed [31:0] out_message;
		logic [31:0]        enqueue_count;
		logic [31:0]        dequeue_count;
	} res_t;

endpackage

/* rtl/message_fifo_with_search.sv */
// Bounded FIFO of (source, message) entries with a content search. Each request on the
// input stream carries one operation in s_axis_tuser: enqueue, dequeue, search by
// message, or clear; every request produces exactly one result on the output stream,
// whose tuser carries the status (ok, queue empty, not found, queue full) and whose
// tdata carries the dequeued or found entry plus the running enqueue and dequeue
// counts. Entries live in a single-port-read ring memory of DEPTH cells with a
// registered read, so the path of a request depends on the operation: enqueue, clear and
// any rejected or empty case go straight from idle to the result state, a dequeue first
// passes through the read state S_DEQ, and a search stays in the scan state while it
// examines entries from the front, up to the first match or, when nothing matches, the
// whole fill level, as the memory delivers one entry per cycle. One request is in flight at a time;
// a finished result waits in the output register, so the next request is taken while
// the previous result has not yet been collected. No clearing pass runs after reset:
// the fill level alone decides which cells hold live entries.
module message_fifo_with_search import mfs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // source_id [15:0], message [47:16]
	input  logic [1:0]   s_axis_tuser,  // mode [1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,  // out_source [15:0], out_message [47:16],
	                                    // enqueue_count [79:48], dequeue_count [111:80]
	output logic [1:0]   m_axis_tuser   // status [1:0]
);

	localparam int AW = $clog2(DEPTH);

	cmd_t          cmd;
	res_t          res;
	logic          res_valid;
	logic          res_ready;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic          out_valid_q;
	res_t          out_q;

	// Unpack the request: the operation travels in tuser, the entry in tdata.
	assign cmd = '{mode: s_axis_tuser, source_id: s_axis_tdata[15:0],
		message: s_axis_tdata[47:16]};

	mfs_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_axis_tvalid),
		.cmd_ready (s_axis_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	mfs_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: it loads a finished result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {out_q.dequeue_count, out_q.enqueue_count,
		out_q.out_message, out_q.out_source};

endmodule

/* rtl/mfs_ram.sv */
module mfs_ram import mfs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/mfs_engine.sv */
module mfs_engine import mfs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int FW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cmd_t          cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output entry_t        ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input  entry_t        ram_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	localparam logic [FW-1:0] FILL_MAX = FW'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

	logic [1:0]        state_q, state_d;
	logic [AW-1:0]     head_q, head_d;
	logic [FW-1:0]     fill_q, fill_d;
	logic [31:0]       enq_q, enq_d;
	logic [31:0]       deq_q, deq_d;
	logic signed [31:0] key_q, key_d;
	logic [AW-1:0]     ptr_q, ptr_d;
	logic [FW-1:0]     off_q, off_d;
	res_t              res_q, res_d;
	logic [AW:0]       tail_sum;
	logic [AW-1:0]     tail;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	// Tail slot: head plus fill level, folded back into the ring.
	always_comb begin
		tail_sum = (AW + 1)'(head_q) + (AW + 1)'(fill_q);
		if (tail_sum >= DEPTH_W) begin
			tail_sum = tail_sum - DEPTH_W;
		end
		tail = tail_sum[AW-1:0];
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		fill_d    = fill_q;
		enq_d     = enq_q;
		deq_d     = deq_q;
		key_d     = key_q;
		ptr_d     = ptr_q;
		off_d     = off_q;
		res_d     = res_q;
		cmd_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_RESP);
		res       = res_q;
		ram_we    = 1'b0;
		ram_waddr = tail;
		ram_wdata = '{source: cmd.source_id, message: cmd.message};
		ram_raddr = head_q;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					res_d = '{status: ST_OK, out_source: '0, out_message: '0,
						enqueue_count: enq_q, dequeue_count: deq_q};
					state_d = S_RESP;
					case (cmd.mode)
						OP_ENQ: begin
							if (fill_q == FILL_MAX) begin
								res_d.status = ST_FULL;
							end else begin
								ram_we              = 1'b1;
								fill_d              = fill_q + 1'b1;
								enq_d               = enq_q + 32'd1;
								res_d.enqueue_count = enq_q + 32'd1;
							end
						end
						OP_DEQ: begin
							if (fill_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								state_d = S_DEQ;
							end
						end
						OP_SRCH: begin
							key_d = cmd.message;
							if (fill_q == '0) begin
								res_d.status = ST_NOTFOUND;
							end else begin
								ptr_d   = ring_next(head_q);
								off_d   = FW'(1);
								state_d = S_SCAN;
							end
						end
						default: begin
							head_d              = '0;
							fill_d              = '0;
							enq_d               = '0;
							deq_d               = '0;
							res_d.enqueue_count = '0;
							res_d.dequeue_count = '0;
						end
					endcase
				end
			end
			S_DEQ: begin
				// The front entry read in the previous cycle is on the read port.
				head_d  = ring_next(head_q);
				fill_d  = fill_q - 1'b1;
				deq_d   = deq_q + 32'd1;
				res_d   = '{status: ST_OK, out_source: ram_rdata.source,
					out_message: ram_rdata.message, enqueue_count: enq_q,
					dequeue_count: deq_q + 32'd1};
				state_d = S_RESP;
			end
			S_SCAN: begin
				// Compare the entry at offset off_q-1 while fetching the next one.
				ram_raddr = ptr_q;
				if (ram_rdata.message == key_q) begin
					res_d = '{status: ST_OK, out_source: ram_rdata.source,
						out_message: ram_rdata.message, enqueue_count: enq_q,
						dequeue_count: deq_q};
					state_d = S_RESP;
				end else if (off_q == fill_q) begin
					res_d = '{status: ST_NOTFOUND, out_source: '0, out_message: '0,
						enqueue_count: enq_q, dequeue_count: deq_q};
					state_d = S_RESP;
				end else begin
					ptr_d = ring_next(ptr_q);
					off_d = off_q + 1'b1;
				end
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			enq_q   <= '0;
			deq_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
			enq_q   <= enq_d;
			deq_q   <= deq_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		ptr_q <= ptr_d;
		off_q <= off_d;
		res_q <= res_d;
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill level above ring depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST)
		else $error("head index outside the ring");

	a_scan_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (off_q != '0 && off_q <= fill_q))
		else $error("search offset outside the live entries");

	a_enq_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cmd_valid && cmd.mode == OP_ENQ && fill_q != FILL_MAX)
		|=> (fill_q == $past(fill_q) + 1'b1 && enq_q == $past(enq_q) + 32'd1))
		else $error("accepted enqueue did not grow the queue");

	a_deq_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEQ) |=> (fill_q == $past(fill_q) - 1'b1 && state_q == S_RESP))
		else $error("dequeue did not shrink the queue");
`endif

endmodule
